// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each one is sampled on clk and is
// held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every edge.
`define ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error(msg);

// Check that an antecedent implies a consequent at the same edge.
`define ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Check that an antecedent implies a consequent at the following edge.
`define ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== src/hwm_pkg.sv =====
package hwm_pkg;

	localparam int BLOCK_W     = 6;
	localparam int SLOT_W      = 4;
	localparam int COEF_W      = 48;
	localparam int PIX_W       = 12;
	localparam int OUT_W       = 32;
	localparam int SUM_W       = 64;
	localparam int NUM_SLOTS   = 16;
	localparam int COEFS_PER_M = 8;
	localparam int CELLS       = 64;
	localparam int FRAC_OUT    = 16;
	localparam int QBITS       = 33;
	localparam int DIV_LAT     = QBITS + 3;
	localparam int MID_DEPTH   = 4;
	localparam int OUT_DEPTH   = 2;

	localparam int GRID_SIDE_DEF      = 8;
	localparam int COORD_BITS_DEF     = 12;
	localparam int COEF_FRAC_BITS_DEF = 32;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_MAP   = 1'b1;

	typedef struct packed {
		logic                     action;
		logic [BLOCK_W-1:0]       block_number;
		logic [SLOT_W-1:0]        coef_slot;
		logic signed [COEF_W-1:0] coef_word;
		logic [PIX_W-1:0]         pixel_x;
		logic [PIX_W-1:0]         pixel_y;
	} hwm_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] fwd_x;
		logic signed [OUT_W-1:0] fwd_y;
		logic signed [OUT_W-1:0] inv_x;
		logic signed [OUT_W-1:0] inv_y;
		logic                    fwd_zero_div;
		logic                    inv_zero_div;
	} hwm_out_t;

	// Numerators and denominators of both matrices, handed from front to back.
	typedef struct packed {
		logic                    bad;
		logic signed [SUM_W-1:0] fnx;
		logic signed [SUM_W-1:0] fny;
		logic signed [SUM_W-1:0] fz;
		logic signed [SUM_W-1:0] inx;
		logic signed [SUM_W-1:0] iny;
		logic signed [SUM_W-1:0] iz;
	} hwm_mid_t;

endpackage

// ===== src/block_homography_warp_map.sv =====
// Channel   Handshake            Beat type   Moves
// item      push / full          hwm_in_t    coefficient writes and map requests
// result    pop / empty          hwm_out_t   one mapped point pair per map beat
//
// One item beat per cycle is taken in steady state while full is low; a map beat
// passes three front stages (the first loads at the edge that takes it), one
// middle queue write, 36 divider stages and one result queue write on its way
// to the result ports. Most of those stages belong to the 33-step restoring
// divider chains in the back part.
// Write beats update the per-slot coefficient memories and produce no result.
// arst_n clears all valid and pointer state; coefficient memories are not cleared.
// A full result queue stalls the back part; the middle queue then fills and
// raises full on the item side.
`include "assert_macros.svh"

module block_homography_warp_map #(
	parameter int GRID_SIDE      = hwm_pkg::GRID_SIDE_DEF,
	parameter int COORD_BITS     = hwm_pkg::COORD_BITS_DEF,
	parameter int COEF_FRAC_BITS = hwm_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  hwm_pkg::hwm_in_t  item,
	output logic              empty,
	input  logic              pop,
	output hwm_pkg::hwm_out_t result
);
	import hwm_pkg::*;

	logic     mid_push, mid_full, mid_pop, mid_empty;
	hwm_mid_t mid_in, mid_out;
	logic     out_push, out_full;
	hwm_out_t out_in;

	// Front: take beats, write coefficients, form sums.
	hwm_front #(
		.GRID_SIDE(GRID_SIDE),
		.COORD_BITS(COORD_BITS),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_front (
		.clk, .arst_n, .push, .full, .item,
		.mid_push, .mid_full, .mid_item(mid_in)
	);

	// Hold sums between the two parts so each stalls on its own.
	hwm_fifo #(.WIDTH($bits(hwm_mid_t)), .DEPTH(MID_DEPTH)) u_mid (
		.clk, .arst_n, .push(mid_push), .full(mid_full), .din(mid_in),
		.pop(mid_pop), .empty(mid_empty), .dout(mid_out)
	);

	// Back: divide, round, saturate.
	hwm_back u_back (
		.clk, .arst_n, .mid_empty, .mid_pop, .mid_item(mid_out),
		.out_push, .out_full, .out_item(out_in)
	);

	// Result queue parts the back pipeline from the consumer.
	hwm_fifo #(.WIDTH($bits(hwm_out_t)), .DEPTH(OUT_DEPTH)) u_out (
		.clk, .arst_n, .push(out_push), .full(out_full), .din(out_in),
		.pop, .empty, .dout(result)
	);

	`ASSERT_IMPLY(a_mid_no_overrun, mid_push, !mid_full, "front pushed into full middle queue")
	`ASSERT_IMPLY(a_full_cause, full, mid_full, "item side stalled without full middle queue")
	`ASSERT_NEXT(a_out_lands, out_push && empty, !empty, "result beat lost on its way out")
endmodule

// ===== src/hwm_fifo.sv =====
module hwm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;
	logic             push_ok, pop_ok;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			case ({push_ok, pop_ok})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== src/hwm_front.sv =====
module hwm_front #(
	parameter int GRID_SIDE      = 8,
	parameter int COORD_BITS     = 12,
	parameter int COEF_FRAC_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  hwm_pkg::hwm_in_t  item,
	output logic              mid_push,
	input  logic              mid_full,
	output hwm_pkg::hwm_mid_t mid_item
);
	import hwm_pkg::*;

	localparam int CELLS_USED = GRID_SIDE * GRID_SIDE;
	localparam logic [PIX_W-1:0] XMASK = PIX_W'((64'd1 << COORD_BITS) - 64'd1);
	localparam logic signed [SUM_W-1:0] Z_ONE = SUM_W'(64'd1 << COEF_FRAC_BITS);
	localparam int PW = COEF_W + PIX_W + 1;

	logic en, acc, in_grid, wr, rd;
	logic v_s1, v_s2, v_s3;

	logic [COEF_W-1:0]       coef_s1 [NUM_SLOTS];
	logic [PIX_W-1:0]        x_s1, y_s1;
	logic                    bad_s1, bad_s2, bad_s3;
	logic signed [PW-1:0]    prod_s2 [2][6];
	logic signed [COEF_W-1:0] cst_s2 [2][2];
	logic signed [SUM_W-1:0] sum_s3 [2][3];

	assign en      = !(v_s3 && mid_full);
	assign full    = !en;
	assign acc     = push && en;
	assign in_grid = ({5'd0, item.block_number} < 11'(CELLS_USED));
	assign wr      = acc && (item.action == ACT_WRITE) && in_grid;
	assign rd      = acc && (item.action == ACT_MAP);

	// One memory per coefficient slot, so a map reads all sixteen at once.
	for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
		logic [COEF_W-1:0] mem [CELLS];
		always_ff @(posedge clk) begin
			if (wr && item.coef_slot == SLOT_W'(k)) begin
				mem[item.block_number] <= item.coef_word;
			end
			if (rd) begin
				coef_s1[k] <= mem[item.block_number];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			x_s1   <= item.pixel_x & XMASK;
			y_s1   <= item.pixel_y & XMASK;
			bad_s1 <= !in_grid;
		end
	end

	// Products of both matrices.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 2; m++) begin
				prod_s2[m][0] <= $signed(coef_s1[m*COEFS_PER_M+0]) * $signed({1'b0, x_s1});
				prod_s2[m][1] <= $signed(coef_s1[m*COEFS_PER_M+1]) * $signed({1'b0, y_s1});
				prod_s2[m][2] <= $signed(coef_s1[m*COEFS_PER_M+3]) * $signed({1'b0, x_s1});
				prod_s2[m][3] <= $signed(coef_s1[m*COEFS_PER_M+4]) * $signed({1'b0, y_s1});
				prod_s2[m][4] <= $signed(coef_s1[m*COEFS_PER_M+6]) * $signed({1'b0, x_s1});
				prod_s2[m][5] <= $signed(coef_s1[m*COEFS_PER_M+7]) * $signed({1'b0, y_s1});
				cst_s2[m][0]  <= $signed(coef_s1[m*COEFS_PER_M+2]);
				cst_s2[m][1]  <= $signed(coef_s1[m*COEFS_PER_M+5]);
			end
			bad_s2 <= bad_s1;
		end
	end

	// Numerator and denominator sums.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 2; m++) begin
				sum_s3[m][0] <= SUM_W'(prod_s2[m][0]) + SUM_W'(prod_s2[m][1])
					+ SUM_W'(cst_s2[m][0]);
				sum_s3[m][1] <= SUM_W'(prod_s2[m][2]) + SUM_W'(prod_s2[m][3])
					+ SUM_W'(cst_s2[m][1]);
				sum_s3[m][2] <= SUM_W'(prod_s2[m][4]) + SUM_W'(prod_s2[m][5]) + Z_ONE;
			end
			bad_s3 <= bad_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign mid_push     = v_s3 && !mid_full;
	assign mid_item.bad = bad_s3;
	assign mid_item.fnx = sum_s3[0][0];
	assign mid_item.fny = sum_s3[0][1];
	assign mid_item.fz  = sum_s3[0][2];
	assign mid_item.inx = sum_s3[1][0];
	assign mid_item.iny = sum_s3[1][1];
	assign mid_item.iz  = sum_s3[1][2];
endmodule

// ===== src/hwm_div.sv =====
module hwm_div (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [hwm_pkg::SUM_W-1:0] num,
	input  logic signed [hwm_pkg::SUM_W-1:0] den,
	output logic [hwm_pkg::OUT_W-1:0]        res,
	output logic                             zero
);
	import hwm_pkg::*;

	logic [SUM_W-1:0]    n_s1, d_s1;
	logic                neg_s1, zero_s1;

	// Iteration chain: index 0 is the setup stage, index i+1 follows step i.
	logic [SUM_W-1:0]    rem_s [QBITS+1];
	logic [SUM_W-1:0]    d_s   [QBITS+1];
	logic [FRAC_OUT-1:0] lo_s  [QBITS+1];
	logic [QBITS-1:0]    q_s   [QBITS+1];
	logic                neg_s [QBITS+1];
	logic                sat_s [QBITS+1];
	logic                zero_s[QBITS+1];

	logic [QBITS-1:0]    mag;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1    <= num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
			d_s1    <= den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
			neg_s1  <= num[SUM_W-1] ^ den[SUM_W-1];
			zero_s1 <= (den == '0);
		end
	end

	// Saturate when the integer part reaches 2^16.
	always_ff @(posedge clk) begin
		if (en) begin
			sat_s[0]  <= (n_s1 >> FRAC_OUT) >= d_s1;
			rem_s[0]  <= n_s1 >> FRAC_OUT;
			lo_s[0]   <= n_s1[FRAC_OUT-1:0];
			d_s[0]    <= d_s1;
			q_s[0]    <= '0;
			neg_s[0]  <= neg_s1;
			zero_s[0] <= zero_s1;
		end
	end

	for (genvar i = 0; i < QBITS; i++) begin : g_step
		logic           nb;
		logic [SUM_W:0] t;
		logic           ge;
		if (i < FRAC_OUT) begin : g_feed
			assign nb = lo_s[i][FRAC_OUT-1-i];
		end else begin : g_zero
			assign nb = 1'b0;
		end
		assign t  = {rem_s[i], nb};
		assign ge = (t >= {1'b0, d_s[i]});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? SUM_W'(t - {1'b0, d_s[i]}) : SUM_W'(t);
				q_s[i+1]    <= {q_s[i][QBITS-2:0], ge};
				d_s[i+1]    <= d_s[i];
				lo_s[i+1]   <= lo_s[i];
				neg_s[i+1]  <= neg_s[i];
				sat_s[i+1]  <= sat_s[i];
				zero_s[i+1] <= zero_s[i];
			end
		end
	end

	// Round half away from zero, then clamp to Q16.16.
	assign mag = QBITS'(({1'b0, q_s[QBITS]} + 1'b1) >> 1);

	always_ff @(posedge clk) begin
		if (en) begin
			zero <= zero_s[QBITS];
			if (sat_s[QBITS]) begin
				res <= neg_s[QBITS] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else if (neg_s[QBITS]) begin
				res <= (mag > 33'h0_8000_0000) ? 32'h8000_0000 : OUT_W'(-mag);
			end else begin
				res <= (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[OUT_W-1:0];
			end
		end
	end
endmodule

// ===== src/hwm_back.sv =====
module hwm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mid_empty,
	output logic              mid_pop,
	input  hwm_pkg::hwm_mid_t mid_item,
	output logic              out_push,
	input  logic              out_full,
	output hwm_pkg::hwm_out_t out_item
);
	import hwm_pkg::*;

	logic             en;
	logic [DIV_LAT-1:0] vld_s, bad_s;
	logic [OUT_W-1:0] res [4];
	logic             zf  [4];
	logic             fz, iz;

	assign en      = !(vld_s[DIV_LAT-1] && out_full);
	assign mid_pop = en && !mid_empty;

	hwm_div u_fx (.clk, .en, .num(mid_item.fnx), .den(mid_item.fz), .res(res[0]), .zero(zf[0]));
	hwm_div u_fy (.clk, .en, .num(mid_item.fny), .den(mid_item.fz), .res(res[1]), .zero(zf[1]));
	hwm_div u_ix (.clk, .en, .num(mid_item.inx), .den(mid_item.iz), .res(res[2]), .zero(zf[2]));
	hwm_div u_iy (.clk, .en, .num(mid_item.iny), .den(mid_item.iz), .res(res[3]), .zero(zf[3]));

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s <= {bad_s[DIV_LAT-2:0], mid_item.bad};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DIV_LAT-2:0], mid_pop};
		end
	end

	// Out-of-grid cells and zero denominators force zeros.
	assign fz       = bad_s[DIV_LAT-1] || zf[0] || zf[1];
	assign iz       = bad_s[DIV_LAT-1] || zf[2] || zf[3];
	assign out_push = vld_s[DIV_LAT-1] && !out_full;

	assign out_item.fwd_x        = fz ? '0 : $signed(res[0]);
	assign out_item.fwd_y        = fz ? '0 : $signed(res[1]);
	assign out_item.inv_x        = iz ? '0 : $signed(res[2]);
	assign out_item.inv_y        = iz ? '0 : $signed(res[3]);
	assign out_item.fwd_zero_div = fz;
	assign out_item.inv_zero_div = iz;
endmodule
